// File: src/rcfd_pkg.sv
`timescale 1ns / 1ps

package rcfd_pkg;

   localparam int unsigned FRAME_LEN  = 18;
   localparam int unsigned STORED_LEN = FRAME_LEN - 1;
   localparam int unsigned COUNT_W    = $clog2(FRAME_LEN);
   localparam int unsigned CH_W       = 11;

   localparam logic [COUNT_W-1:0] LAST_INDEX = COUNT_W'(FRAME_LEN - 1);

   localparam logic [1:0] SW_UP   = 2'd1;
   localparam logic [1:0] SW_MID  = 2'd3;
   localparam logic [1:0] SW_DOWN = 2'd2;
   localparam logic [3:0] SW_BOTH_DOWN = {SW_DOWN, SW_DOWN};

   typedef enum logic [0:0] {
      CSR_CHANNEL_OFFSET    = 1'b0,
      CSR_STICK_ERROR_LIMIT = 1'b1
   } csr_index_type;

   typedef logic [FRAME_LEN-1:0][7:0] frame_type;

   typedef struct packed {
      logic [CH_W-1:0] channel_offset;
      logic [CH_W-1:0] stick_error_limit;
   } cfg_type;

   typedef struct packed {
      logic      valid;
      frame_type bytes;
   } frame_xfer_type;

endpackage

// File: src/rcfd_collect.sv
`timescale 1ns / 1ps

module rcfd_collect (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_rx_byte,
   input  logic                   req_frame_start,
   input  logic                   frame_ready,
   output rcfd_pkg::frame_xfer_type frame_out
);
   import rcfd_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         bytes_ff [STORED_LEN];
   logic               frame_valid_ff, frame_valid_in;
   frame_type          frame_ff;
   logic [COUNT_W-1:0] idx;
   logic               accept;
   logic               last;

   assign req_ready = !frame_valid_ff || frame_ready;
   assign accept    = req_valid && req_ready;
   assign idx       = req_frame_start ? '0 : count_ff;
   assign last      = (idx >= LAST_INDEX);

   always_comb begin
      count_in       = count_ff;
      frame_valid_in = frame_valid_ff;
      if (frame_valid_ff && frame_ready) begin
         frame_valid_in = 1'b0;
      end
      if (accept) begin
         if (last) begin
            count_in       = '0;
            frame_valid_in = 1'b1;
         end else begin
            count_in = idx + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         frame_valid_ff <= 1'b0;
      end else begin
         count_ff       <= count_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (last) begin
            for (int i = 0; i < STORED_LEN; i++) begin
               frame_ff[i] <= bytes_ff[i];
            end
            frame_ff[FRAME_LEN-1] <= req_rx_byte;
         end else begin
            bytes_ff[idx] <= req_rx_byte;
         end
      end
   end

   assign frame_out.valid = frame_valid_ff;
   assign frame_out.bytes = frame_ff;

   // The byte count never runs past the last byte of a frame.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_INDEX)
      else $error("byte count out of range");

   // The last byte of a frame always hands a frame to the decoder.
   a_last_loads: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_frame_start && count_ff == LAST_INDEX) |=> frame_valid_ff)
      else $error("completed frame not handed on");

endmodule

// File: src/rcfd_decode.sv
`timescale 1ns / 1ps

module rcfd_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  rcfd_pkg::cfg_type        cfg,
   input  rcfd_pkg::frame_xfer_type frame_in,
   output logic                     frame_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [10:0]       rsp_stick_a,
   output logic signed [10:0]       rsp_stick_b,
   output logic signed [10:0]       rsp_stick_c,
   output logic signed [10:0]       rsp_stick_d,
   output logic [3:0]               rsp_switch_positions,
   output logic signed [15:0]       rsp_mouse_dx,
   output logic signed [15:0]       rsp_mouse_dy,
   output logic signed [15:0]       rsp_mouse_dz,
   output logic [1:0]               rsp_mouse_buttons,
   output logic [15:0]              rsp_key_bits,
   output logic signed [15:0]       rsp_wheel_value,
   output logic [15:0]              rsp_status_flags
);
   import rcfd_pkg::*;

   function automatic logic [6:0] switch_group(logic [1:0] cur, logic [1:0] prev);
      logic [6:0] g;
      g = '0;
      unique case (cur)
         SW_MID: begin
            g[1] = 1'b1;
            if (prev == SW_UP) begin
               g[3] = 1'b1;
            end else if (prev == SW_DOWN) begin
               g[4] = 1'b1;
            end
         end
         SW_UP: begin
            g[0] = 1'b1;
            g[5] = (prev == SW_MID);
         end
         SW_DOWN: begin
            g[2] = 1'b1;
            g[6] = (prev == SW_MID);
         end
         default: g = '0;
      endcase
      return g;
   endfunction

   function automatic logic signed [CH_W-1:0] sat11(logic signed [CH_W:0] d);
      logic signed [CH_W-1:0] r;
      if (d[CH_W] != d[CH_W-1]) begin
         r = d[CH_W] ? {1'b1, {(CH_W-1){1'b0}}} : {1'b0, {(CH_W-1){1'b1}}};
      end else begin
         r = d[CH_W-1:0];
      end
      return r;
   endfunction

   frame_type               b;
   logic [CH_W-1:0]         raw [4];
   logic signed [CH_W:0]    diff [4];
   logic [CH_W:0]           mag [4];
   logic                    ok;
   logic [1:0]              sw1, sw2;
   logic [14:0]             held_new;
   logic                    load;

   logic                    rsp_valid_ff;
   logic [1:0]              prev_left_ff, prev_left_in;
   logic [1:0]              prev_right_ff, prev_right_in;
   logic [14:0]             held_ff, held_in;
   logic signed [10:0]      stick_ff [4];
   logic [3:0]              switch_ff;
   logic [15:0]             dx_ff, dy_ff, dz_ff, keys_ff, wheel_ff, status_ff;
   logic [1:0]              buttons_ff;

   assign b           = frame_in.bytes;
   assign frame_ready = !rsp_valid_ff || rsp_ready;
   assign load        = frame_in.valid && frame_ready;

   assign raw[0] = {b[1][2:0], b[0]};
   assign raw[1] = {b[2][5:0], b[1][7:3]};
   assign raw[2] = {b[4][0], b[3], b[2][7:6]};
   assign raw[3] = {b[5][3:0], b[4][7:1]};
   assign sw1    = b[5][5:4];
   assign sw2    = b[5][7:6];

   always_comb begin
      ok = (sw1 != 2'd0) && (sw2 != 2'd0);
      for (int i = 0; i < 4; i++) begin
         diff[i] = $signed({1'b0, raw[i]}) - $signed({1'b0, cfg.channel_offset});
         mag[i]  = diff[i][CH_W] ? (CH_W+1)'(-diff[i]) : diff[i];
         if (mag[i] > {1'b0, cfg.stick_error_limit}) begin
            ok = 1'b0;
         end
      end
      held_new = {(sw1 == SW_DOWN) && (sw2 == SW_DOWN),
                  switch_group(sw2, prev_right_ff),
                  switch_group(sw1, prev_left_ff)};
   end

   always_comb begin
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      held_in       = held_ff;
      if (load) begin
         if (ok) begin
            prev_left_in  = sw1;
            prev_right_in = sw2;
            held_in       = held_new;
         end else begin
            prev_left_in  = SW_DOWN;
            prev_right_in = SW_DOWN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         held_ff       <= '0;
      end else begin
         if (frame_ready) begin
            rsp_valid_ff <= frame_in.valid;
         end
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
         held_ff       <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (ok) begin
            for (int i = 0; i < 4; i++) begin
               stick_ff[i] <= sat11(diff[i]);
            end
            switch_ff  <= {sw2, sw1};
            dx_ff      <= {b[7], b[6]};
            dy_ff      <= {b[9], b[8]};
            dz_ff      <= {b[11], b[10]};
            buttons_ff <= {b[13] != 8'd0, b[12] != 8'd0};
            keys_ff    <= {b[15], b[14]};
            wheel_ff   <= {b[17], b[16]} - {5'd0, cfg.channel_offset};
            status_ff  <= {held_new, 1'b1};
         end else begin
            for (int i = 0; i < 4; i++) begin
               stick_ff[i] <= '0;
            end
            switch_ff  <= SW_BOTH_DOWN;
            dx_ff      <= '0;
            dy_ff      <= '0;
            dz_ff      <= '0;
            buttons_ff <= '0;
            keys_ff    <= '0;
            wheel_ff   <= '0;
            status_ff  <= {held_ff, 1'b0};
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_stick_a          = stick_ff[0];
   assign rsp_stick_b          = stick_ff[1];
   assign rsp_stick_c          = stick_ff[2];
   assign rsp_stick_d          = stick_ff[3];
   assign rsp_switch_positions = switch_ff;
   assign rsp_mouse_dx         = dx_ff;
   assign rsp_mouse_dy         = dy_ff;
   assign rsp_mouse_dz         = dz_ff;
   assign rsp_mouse_buttons    = buttons_ff;
   assign rsp_key_bits         = keys_ff;
   assign rsp_wheel_value      = wheel_ff;
   assign rsp_status_flags     = status_ff;

   // A rejected frame reports both switches down and cleared values.
   a_error_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_status_flags[0]) |->
         (rsp_switch_positions == SW_BOTH_DOWN && rsp_stick_a == '0 && rsp_key_bits == '0))
      else $error("rejected frame not cleared");

   // An accepted frame never reports a switch reading of zero.
   a_ok_switches: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status_flags[0]) |->
         (rsp_switch_positions[1:0] != 2'd0 && rsp_switch_positions[3:2] != 2'd0))
      else $error("accepted frame with invalid switch");

   // After a rejected frame both remembered switches read down.
   a_error_prev_down: assert property (@(posedge clock) disable iff (reset)
      (load && !ok) |=> (prev_left_ff == SW_DOWN && prev_right_ff == SW_DOWN))
      else $error("switch history not forced down");

endmodule

// File: src/rc_receiver_frame_decoder_top.sv
`timescale 1ns / 1ps
// Path: a result passes the collector's frame register and then the decode register.
// Throughput: one byte per cycle while req_ready is high; set by the byte collector and
// the one-stage decode register, with at most one result per 18 bytes.
// Reset: synchronous, active high; clears the byte count, valid flags, switch
// history and held switch flags, and loads offset 1024 and limit 700.

module rc_receiver_frame_decoder_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [0:0]          csr_index,
   input  logic [10:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_rx_byte,
   input  logic                req_frame_start,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [10:0]  rsp_stick_a,
   output logic signed [10:0]  rsp_stick_b,
   output logic signed [10:0]  rsp_stick_c,
   output logic signed [10:0]  rsp_stick_d,
   output logic [3:0]          rsp_switch_positions,
   output logic signed [15:0]  rsp_mouse_dx,
   output logic signed [15:0]  rsp_mouse_dy,
   output logic signed [15:0]  rsp_mouse_dz,
   output logic [1:0]          rsp_mouse_buttons,
   output logic [15:0]         rsp_key_bits,
   output logic signed [15:0]  rsp_wheel_value,
   output logic [15:0]         rsp_status_flags
);
   import rcfd_pkg::*;

   localparam logic [CH_W-1:0] OFFSET_RESET = CH_W'(1024);
   localparam logic [CH_W-1:0] LIMIT_RESET  = CH_W'(700);

   cfg_type        cfg_ff;
   frame_xfer_type frame_xfer;
   logic           frame_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_offset    <= OFFSET_RESET;
         cfg_ff.stick_error_limit <= LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHANNEL_OFFSET:    cfg_ff.channel_offset    <= csr_wdata;
            CSR_STICK_ERROR_LIMIT: cfg_ff.stick_error_limit <= csr_wdata;
         endcase
      end
   end

   rcfd_collect u_collect (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .frame_ready     (frame_ready),
      .frame_out       (frame_xfer)
   );

   rcfd_decode u_decode (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .frame_in             (frame_xfer),
      .frame_ready          (frame_ready),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_stick_a          (rsp_stick_a),
      .rsp_stick_b          (rsp_stick_b),
      .rsp_stick_c          (rsp_stick_c),
      .rsp_stick_d          (rsp_stick_d),
      .rsp_switch_positions (rsp_switch_positions),
      .rsp_mouse_dx         (rsp_mouse_dx),
      .rsp_mouse_dy         (rsp_mouse_dy),
      .rsp_mouse_dz         (rsp_mouse_dz),
      .rsp_mouse_buttons    (rsp_mouse_buttons),
      .rsp_key_bits         (rsp_key_bits),
      .rsp_wheel_value      (rsp_wheel_value),
      .rsp_status_flags     (rsp_status_flags)
   );

endmodule

// File: sim/tb_rc_receiver_frame_decoder_top.sv
`timescale 1ns / 1ps

module tb_rc_receiver_frame_decoder_top;
   import rcfd_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_CYCLES  = 300;
   localparam int FRAME_BITS   = FRAME_LEN * 8;

   localparam logic [1:0] SW_NONE = 2'd0;

   localparam logic [6:0] GRP_UP       = 7'd1;
   localparam logic [6:0] GRP_MID      = 7'd2;
   localparam logic [6:0] GRP_DOWN     = 7'd4;
   localparam logic [6:0] GRP_UP2MID   = 7'd8;
   localparam logic [6:0] GRP_DOWN2MID = 7'd16;
   localparam logic [6:0] GRP_MID2UP   = 7'd32;
   localparam logic [6:0] GRP_MID2DOWN = 7'd64;

   localparam int START_LOW  = 0;
   localparam int START_HIGH = 1;
   localparam int START_AUTO = 2;

   typedef struct packed {
      logic [10:0] stick_a;
      logic [10:0] stick_b;
      logic [10:0] stick_c;
      logic [10:0] stick_d;
      logic [3:0]  switch_positions;
      logic [15:0] mouse_dx;
      logic [15:0] mouse_dy;
      logic [15:0] mouse_dz;
      logic [1:0]  mouse_buttons;
      logic [15:0] key_bits;
      logic [15:0] wheel_value;
      logic [15:0] status_flags;
   } rc_frame_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_en = 1'b0;
   logic [0:0]         csr_index = CSR_CHANNEL_OFFSET;
   logic [10:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = '0;
   logic               req_frame_start = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [10:0] rsp_stick_a;
   logic signed [10:0] rsp_stick_b;
   logic signed [10:0] rsp_stick_c;
   logic signed [10:0] rsp_stick_d;
   logic [3:0]         rsp_switch_positions;
   logic signed [15:0] rsp_mouse_dx;
   logic signed [15:0] rsp_mouse_dy;
   logic signed [15:0] rsp_mouse_dz;
   logic [1:0]         rsp_mouse_buttons;
   logic [15:0]        rsp_key_bits;
   logic signed [15:0] rsp_wheel_value;
   logic [15:0]        rsp_status_flags;

   logic [10:0] cfg_offset = 11'd1024;
   logic [10:0] cfg_limit  = 11'd700;
   int unsigned pred_count = 0;
   logic [7:0]  pred_bytes [STORED_LEN];
   logic [1:0]  pred_prev_left  = SW_NONE;
   logic [1:0]  pred_prev_right = SW_NONE;
   logic [14:0] pred_held = '0;

   rc_frame_type expected_frames [$];
   rc_frame_type want;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_cycles = 0;
   int cycle_count = 0;
   int failure_count = 0;
   int bytes_sent = 0;
   int frames_checked = 0;
   int csr_writes = 0;

   rc_receiver_frame_decoder_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_byte          (req_rx_byte),
      .req_frame_start      (req_frame_start),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_stick_a          (rsp_stick_a),
      .rsp_stick_b          (rsp_stick_b),
      .rsp_stick_c          (rsp_stick_c),
      .rsp_stick_d          (rsp_stick_d),
      .rsp_switch_positions (rsp_switch_positions),
      .rsp_mouse_dx         (rsp_mouse_dx),
      .rsp_mouse_dy         (rsp_mouse_dy),
      .rsp_mouse_dz         (rsp_mouse_dz),
      .rsp_mouse_buttons    (rsp_mouse_buttons),
      .rsp_key_bits         (rsp_key_bits),
      .rsp_wheel_value      (rsp_wheel_value),
      .rsp_status_flags     (rsp_status_flags)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // The receiver stalls at random, except during a long hold-off when it refuses everything.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic logic [6:0] switch_flag_group(logic [1:0] cur, logic [1:0] prev);
      logic [6:0] g;
      g = '0;
      if (cur == SW_MID) begin
         g = g | GRP_MID;
         if (prev == SW_UP) g = g | GRP_UP2MID;
         else if (prev == SW_DOWN) g = g | GRP_DOWN2MID;
      end else if (cur == SW_UP) begin
         g = g | GRP_UP;
         if (prev == SW_MID) g = g | GRP_MID2UP;
      end else if (cur == SW_DOWN) begin
         g = g | GRP_DOWN;
         if (prev == SW_MID) g = g | GRP_MID2DOWN;
      end
      return g;
   endfunction

   task automatic track_frame_byte(input logic [7:0] rx, input logic start);
      int unsigned idx;
      int i;
      int d;
      int mag;
      int sat;
      logic [FRAME_BITS-1:0] v;
      logic [10:0] raw [4];
      logic [1:0] s1;
      logic [1:0] s2;
      logic ok;
      logic [10:0] st [4];
      rc_frame_type f;
      idx = start ? 0 : pred_count;
      if (idx < STORED_LEN) begin
         pred_bytes[idx] = rx;
         pred_count = idx + 1;
      end else begin
         pred_count = 0;
         for (i = 0; i < STORED_LEN; i++) v[8*i +: 8] = pred_bytes[i];
         v[8*STORED_LEN +: 8] = rx;
         raw[0] = v[10:0];
         raw[1] = v[21:11];
         raw[2] = v[32:22];
         raw[3] = v[43:33];
         s1 = v[45:44];
         s2 = v[47:46];
         ok = (s1 != SW_NONE) && (s2 != SW_NONE);
         for (i = 0; i < 4; i++) begin
            d = int'(raw[i]);
            d = d - int'(cfg_offset);
            mag = (d < 0) ? -d : d;
            if (mag > int'(cfg_limit)) ok = 1'b0;
            sat = (d > 1023) ? 1023 : ((d < -1024) ? -1024 : d);
            st[i] = sat[10:0];
         end
         f = '0;
         if (ok) begin
            pred_held = {(s1 == SW_DOWN) && (s2 == SW_DOWN),
                         switch_flag_group(s2, pred_prev_right),
                         switch_flag_group(s1, pred_prev_left)};
            f.stick_a = st[0];
            f.stick_b = st[1];
            f.stick_c = st[2];
            f.stick_d = st[3];
            f.switch_positions = {s2, s1};
            f.mouse_dx = v[63:48];
            f.mouse_dy = v[79:64];
            f.mouse_dz = v[95:80];
            f.mouse_buttons = {v[111:104] != 8'd0, v[103:96] != 8'd0};
            f.key_bits = v[127:112];
            f.wheel_value = v[143:128] - {5'd0, cfg_offset};
            f.status_flags = {pred_held, 1'b1};
         end else begin
            s1 = SW_DOWN;
            s2 = SW_DOWN;
            f.switch_positions = SW_BOTH_DOWN;
            f.status_flags = {pred_held, 1'b0};
         end
         pred_prev_left = s1;
         pred_prev_right = s2;
         expected_frames.push_back(f);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         failure_count++;
         if (failure_count <= 10)
            $display("Mismatch in %s at cycle %0d: expected %h, got %h",
                     name, cycle_count, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frames.size() == 0) begin
            failure_count++;
            if (failure_count <= 10)
               $display("Unexpected result transaction at cycle %0d", cycle_count);
         end else begin
            want = expected_frames.pop_front();
            frames_checked++;
            check_field("stick_a", {5'd0, want.stick_a}, {5'd0, rsp_stick_a});
            check_field("stick_b", {5'd0, want.stick_b}, {5'd0, rsp_stick_b});
            check_field("stick_c", {5'd0, want.stick_c}, {5'd0, rsp_stick_c});
            check_field("stick_d", {5'd0, want.stick_d}, {5'd0, rsp_stick_d});
            check_field("switch_positions", {12'd0, want.switch_positions},
                        {12'd0, rsp_switch_positions});
            check_field("mouse_dx", want.mouse_dx, {rsp_mouse_dx});
            check_field("mouse_dy", want.mouse_dy, {rsp_mouse_dy});
            check_field("mouse_dz", want.mouse_dz, {rsp_mouse_dz});
            check_field("mouse_buttons", {14'd0, want.mouse_buttons},
                        {14'd0, rsp_mouse_buttons});
            check_field("key_bits", want.key_bits, rsp_key_bits);
            check_field("wheel_value", want.wheel_value, {rsp_wheel_value});
            check_field("status_flags", want.status_flags, rsp_status_flags);
         end
      end
   end

   task automatic send_byte(input logic [7:0] rx, input logic start);
      int gap;
      gap = 0;
      while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      req_frame_start <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_frame_byte(rx, start);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [FRAME_BITS-1:0] frame, input int len,
                             input int start_mode);
      int i;
      logic start;
      for (i = 0; i < len; i++) begin
         if (i != 0) start = 1'b0;
         else if (start_mode == START_AUTO) start = (pred_count != 0) || $urandom_range(1);
         else start = (start_mode == START_HIGH);
         send_byte(frame[8*i +: 8], start);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [10:0] value);
      drain();
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_CHANNEL_OFFSET) cfg_offset = value;
      else cfg_limit = value;
      csr_writes++;
   endtask

   task automatic configure(input logic [10:0] offset, input logic [10:0] limit);
      write_csr(CSR_CHANNEL_OFFSET, offset);
      write_csr(CSR_STICK_ERROR_LIMIT, limit);
   endtask

   function automatic logic [FRAME_BITS-1:0] build_frame(
         logic [10:0] ch0, logic [10:0] ch1, logic [10:0] ch2, logic [10:0] ch3,
         logic [1:0] s1, logic [1:0] s2, logic [15:0] dx, logic [15:0] dy,
         logic [15:0] dz, logic [7:0] btn_l, logic [7:0] btn_r,
         logic [15:0] keys, logic [15:0] wheel);
      return {wheel, keys, btn_r, btn_l, dz, dy, dx, s2, s1, ch3, ch2, ch1, ch0};
   endfunction

   function automatic logic [FRAME_BITS-1:0] center_frame(logic [1:0] s1, logic [1:0] s2);
      return build_frame(cfg_offset, cfg_offset, cfg_offset, cfg_offset, s1, s2,
                         16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                         8'($urandom), 16'($urandom), 16'($urandom));
   endfunction

   function automatic logic [FRAME_BITS-1:0] random_frame(bit well_formed);
      int i;
      int d;
      int pos;
      logic [10:0] ch [4];
      logic [1:0] s1;
      logic [1:0] s2;
      logic [7:0] btn_l;
      logic [7:0] btn_r;
      for (i = 0; i < 4; i++) begin
         if (!well_formed || $urandom_range(9) == 0) begin
            ch[i] = 11'($urandom_range(2047));
         end else begin
            d = int'($urandom_range(2 * cfg_limit));
            d = d - int'(cfg_limit);
            pos = int'(cfg_offset) + d;
            if (pos < 0) pos = 0;
            if (pos > 2047) pos = 2047;
            ch[i] = pos[10:0];
         end
      end
      s1 = well_formed ? 2'($urandom_range(1, 3)) : 2'($urandom_range(3));
      s2 = well_formed ? 2'($urandom_range(1, 3)) : 2'($urandom_range(3));
      btn_l = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom);
      btn_r = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom);
      return build_frame(ch[0], ch[1], ch[2], ch[3], s1, s2, 16'($urandom),
                         16'($urandom), 16'($urandom), btn_l, btn_r, 16'($urandom),
                         16'($urandom));
   endfunction

   task automatic send_noise(input int count);
      int i;
      for (i = 0; i < count; i++) send_byte(8'($urandom), $urandom_range(9) == 0);
   endtask

   task automatic test_frame_alignment_and_limits();
      send_frame(build_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, SW_UP, SW_UP,
                             16'h8000, 16'h7fff, 16'h0000, 8'h00, 8'hff, 16'hffff,
                             16'h0000), FRAME_LEN, START_HIGH);
      send_frame(build_frame(11'd0, 11'd2047, 11'd0, 11'd2047, SW_MID, SW_DOWN,
                             16'hffff, 16'h0000, 16'h8000, 8'hff, 8'h00, 16'h0000,
                             16'hffff), 7, START_HIGH);
      send_frame(build_frame(11'd1724, 11'd324, 11'd1724, 11'd324, SW_MID, SW_DOWN,
                             16'h7fff, 16'h8000, 16'hffff, 8'h01, 8'h80, 16'h5a5a,
                             16'h0400), FRAME_LEN, START_HIGH);
      send_frame(center_frame(SW_UP, SW_MID), FRAME_LEN, START_LOW);
      send_frame(build_frame(11'd1725, 11'd1024, 11'd1024, 11'd1024, SW_UP, SW_UP,
                             16'h1234, 16'h5678, 16'h9abc, 8'h11, 8'h22, 16'h3344,
                             16'h5566), FRAME_LEN, START_HIGH);
      send_frame(build_frame(11'd1024, 11'd1024, 11'd1024, 11'd323, SW_UP, SW_UP,
                             16'h1234, 16'h5678, 16'h9abc, 8'h11, 8'h22, 16'h3344,
                             16'h5566), FRAME_LEN, START_HIGH);
      send_frame(center_frame(SW_NONE, SW_UP), FRAME_LEN, START_LOW);
      send_frame(center_frame(SW_MID, SW_NONE), FRAME_LEN, START_HIGH);
      send_frame(center_frame(SW_MID, SW_MID), FRAME_LEN, START_HIGH);
      send_frame(center_frame(SW_UP, SW_DOWN), FRAME_LEN, START_HIGH);
      send_frame(center_frame(SW_MID, SW_MID), FRAME_LEN, START_HIGH);
      send_frame(center_frame(SW_DOWN, SW_UP), FRAME_LEN, START_HIGH);
      send_frame(center_frame(SW_DOWN, SW_DOWN), FRAME_LEN, START_HIGH);
      send_frame(center_frame(SW_UP, SW_DOWN), FRAME_LEN, START_LOW);
      drain();
   endtask

   task automatic test_stick_saturation();
      configure(11'd0, 11'd2047);
      send_frame(build_frame(11'd2047, 11'd0, 11'd1024, 11'd1023, SW_UP, SW_MID,
                             16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                             8'($urandom), 16'($urandom), 16'h0000), FRAME_LEN,
                 START_HIGH);
      configure(11'd2047, 11'd2047);
      send_frame(build_frame(11'd0, 11'd2047, 11'd1023, 11'd1024, SW_MID, SW_UP,
                             16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                             8'($urandom), 16'($urandom), 16'h0000), FRAME_LEN,
                 START_HIGH);
      configure(11'd2047, 11'd0);
      send_frame(build_frame(11'd2047, 11'd2047, 11'd2047, 11'd2047, SW_DOWN, SW_MID,
                             16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                             8'($urandom), 16'($urandom), 16'hffff), FRAME_LEN,
                 START_HIGH);
      send_frame(build_frame(11'd2047, 11'd2046, 11'd2047, 11'd2047, SW_DOWN, SW_MID,
                             16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                             8'($urandom), 16'($urandom), 16'hffff), FRAME_LEN,
                 START_HIGH);
      configure(11'd0, 11'd0);
      send_frame(build_frame(11'd0, 11'd0, 11'd0, 11'd0, SW_MID, SW_MID,
                             16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                             8'($urandom), 16'($urandom), 16'($urandom)), FRAME_LEN,
                 START_HIGH);
      drain();
   endtask

   task automatic run_traffic_phase(input int idle_pct, input int stall_pct,
                                    input int frames);
      int i;
      int pick;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (i = 0; i < frames; i++) begin
         pick = $urandom_range(99);
         if (pick < 75) send_frame(random_frame(1), FRAME_LEN, START_AUTO);
         else if (pick < 85) send_frame(random_frame(0), FRAME_LEN, START_AUTO);
         else if (pick < 93) send_frame(random_frame(1), $urandom_range(1, 17), START_AUTO);
         else send_noise($urandom_range(1, 20));
      end
      drain();
   endtask

   task automatic test_random_traffic();
      configure(11'd1024, 11'd700);
      run_traffic_phase(0, 0, 6);
      configure(11'd0, 11'd2047);
      run_traffic_phase(70, 0, 6);
      configure(11'd2047, 11'd0);
      run_traffic_phase(0, 70, 6);
      configure(11'($urandom_range(2047)), 11'($urandom_range(2047)));
      run_traffic_phase(34, 34, 6);
   endtask

   // With the output held off, the decoder fills up and must stall the byte stream.
   task automatic test_output_backpressure();
      int i;
      configure(11'($urandom_range(512, 1536)), 11'($urandom_range(300, 1500)));
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_cycles = HOLD_CYCLES;
      for (i = 0; i < 8; i++) send_frame(random_frame(1), FRAME_LEN, START_AUTO);
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_frame_alignment_and_limits();
      test_stick_saturation();
      test_random_traffic();
      test_output_backpressure();
      drain();
      failure_count += expected_frames.size();
      $display("Run covered %0d bytes, %0d decoded frames and %0d register writes,",
               bytes_sent, frames_checked, csr_writes);
      $display("with sender gaps, receiver stalls and one long output hold-off.");
      if (failure_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d failures", failure_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
